@@ sv/dds_pkg.sv @@
// Shared types, codes and constant tables of the four-digit display scanner.
package dds_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [1:0]  pos_t;
  typedef logic [15:0] value_t;
  typedef logic [13:0] mod_t;
  typedef logic [3:0]  digit_t;
  typedef logic [6:0]  seg_t;
  typedef logic [27:0] prod_t;
  typedef logic [4:0]  shamt_t;

  typedef struct packed {
    pos_t   pos;
    value_t value;
  } tick_t;

  typedef struct packed {
    pos_t pos;
    mod_t low4;
  } low4_t;

  typedef struct packed {
    pos_t pos;
    mod_t quot;
    logic blank;
  } quot_t;

  // Value modulo 10000; the quotient of a 16-bit value is at most six.
  function automatic mod_t mod_10000(value_t v);
    value_t r;
    if (v >= 16'd60000) begin
      r = v - 16'd60000;
    end else if (v >= 16'd50000) begin
      r = v - 16'd50000;
    end else if (v >= 16'd40000) begin
      r = v - 16'd40000;
    end else if (v >= 16'd30000) begin
      r = v - 16'd30000;
    end else if (v >= 16'd20000) begin
      r = v - 16'd20000;
    end else if (v >= 16'd10000) begin
      r = v - 16'd10000;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

  // Reciprocal of 10^pos, scaled by 2^shift; exact for values below 10000.
  function automatic mod_t recip(pos_t p);
    mod_t k;
    unique case (p)
      2'd0: k = 14'd1;
      2'd1: k = 14'd6554;
      2'd2: k = 14'd5243;
      2'd3: k = 14'd8389;
      default: k = 14'd1;
    endcase
    return k;
  endfunction

  function automatic shamt_t recip_shift(pos_t p);
    shamt_t s;
    unique case (p)
      2'd0: s = 5'd0;
      2'd1: s = 5'd16;
      2'd2: s = 5'd19;
      2'd3: s = 5'd23;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic mod_t place(pos_t p);
    mod_t w;
    unique case (p)
      2'd0: w = 14'd1;
      2'd1: w = 14'd10;
      2'd2: w = 14'd100;
      2'd3: w = 14'd1000;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  // Segments a to g in bits 0 to 6.
  function automatic seg_t seg_decode(digit_t d);
    seg_t s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h27;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ sv/dds_front.sv @@
// Request intake: byte assembly, scan position, shown value and the tick register.
module dds_front import dds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_received_byte,
  output logic       tick_valid,
  input  logic       tick_ready,
  output tick_t      tick
);

  logic   phase_r, phase_nxt;
  value_t held_r, held_nxt;
  value_t shown_r, shown_nxt;
  pos_t   pos_r, pos_nxt;
  logic   tick_valid_r, tick_valid_nxt;
  tick_t  tick_r, tick_nxt;
  logic   accept;
  value_t view;

  assign in_ready = !tick_valid_r || tick_ready;
  assign accept   = in_valid && in_ready;

  // At position 0 the held value is latched for display.
  assign view = (pos_r == 2'd0) ? held_r : shown_r;

  always_comb begin
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    shown_nxt      = shown_r;
    pos_nxt        = pos_r;
    tick_nxt       = tick_r;
    tick_valid_nxt = tick_valid_r;
    if (in_ready) begin
      tick_valid_nxt = accept && (in_operation == OP_TICK);
    end
    if (accept) begin
      unique case (in_operation)
        OP_BYTE: begin
          if (phase_r) begin
            held_nxt = {in_received_byte, held_r[7:0]};
          end else begin
            held_nxt = {held_r[15:8], in_received_byte};
          end
          phase_nxt = !phase_r;
        end
        OP_TICK: begin
          shown_nxt      = view;
          pos_nxt        = pos_r + 2'd1;
          tick_nxt.pos   = pos_r;
          tick_nxt.value = view;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 1'b0;
      held_r       <= '0;
      shown_r      <= '0;
      pos_r        <= '0;
      tick_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      shown_r      <= shown_nxt;
      pos_r        <= pos_nxt;
      tick_valid_r <= tick_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r <= tick_nxt;
  end

  assign tick_valid = tick_valid_r;
  assign tick       = tick_r;

endmodule

@@ sv/dds_conv.sv @@
// Decimal reduction: value modulo 10000, then scaling down to the selected digit.
module dds_conv import dds_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  tick_t up,
  output logic  dn_valid,
  input  logic  dn_ready,
  output quot_t dn
);

  logic  s2_valid_r, s2_valid_nxt;
  low4_t s2_r, s2_nxt;
  logic  s3_valid_r, s3_valid_nxt;
  quot_t s3_r, s3_nxt;
  logic  s2_en, s3_en;
  prod_t prod;

  assign s3_en    = !s3_valid_r || dn_ready;
  assign s2_en    = !s2_valid_r || s3_en;
  assign up_ready = s2_en;

  assign prod = prod_t'(s2_r.low4) * prod_t'(recip(s2_r.pos));

  always_comb begin
    s2_valid_nxt = s2_en ? up_valid : s2_valid_r;
    s2_nxt       = s2_r;
    if (s2_en) begin
      s2_nxt.pos  = up.pos;
      s2_nxt.low4 = mod_10000(up.value);
    end
    s3_valid_nxt = s3_en ? s2_valid_r : s3_valid_r;
    s3_nxt       = s3_r;
    if (s3_en) begin
      s3_nxt.pos   = s2_r.pos;
      s3_nxt.quot  = mod_t'(prod >> recip_shift(s2_r.pos));
      // A higher digit is dark while it and all above it are zero.
      s3_nxt.blank = (s2_r.pos != 2'd0) && (s2_r.low4 < place(s2_r.pos));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  assign dn_valid = s3_valid_r;
  assign dn       = s3_r;

endmodule

@@ sv/dds_out.sv @@
// Result stage: last decimal digit, segment decode, digit select and output register.
module dds_out import dds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  quot_t      up,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_digit_enable_n,
  output logic [6:0] out_segments
);

  logic       valid_r, valid_nxt;
  logic [3:0] enable_n_r, enable_n_nxt;
  seg_t       seg_r, seg_nxt;
  logic       en;
  prod_t      prod;
  mod_t       tens;
  digit_t     digit;

  assign en       = !valid_r || out_ready;
  assign up_ready = en;

  // Quotient by ten through a scaled reciprocal, then the remainder.
  assign prod  = prod_t'(up.quot) * prod_t'(14'd6554);
  assign tens  = mod_t'(prod >> 16);
  assign digit = digit_t'(up.quot - mod_t'(tens * 14'd10));

  always_comb begin
    valid_nxt    = en ? up_valid : valid_r;
    enable_n_nxt = enable_n_r;
    seg_nxt      = seg_r;
    if (en) begin
      enable_n_nxt = ~(4'b0001 << up.pos);
      seg_nxt      = up.blank ? 7'h00 : seg_decode(digit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enable_n_r <= enable_n_nxt;
    seg_r      <= seg_nxt;
  end

  assign out_valid          = valid_r;
  assign out_digit_enable_n = enable_n_r;
  assign out_segments       = seg_r;

endmodule

@@ sv/four_digit_decimal_display_scanner.sv @@
// Top level of the four-digit decimal display scanner.
//
//   channel  direction  handshake           payload
//   in_      request    in_valid/in_ready   in_operation, in_received_byte
//   out_     result     out_valid/out_ready out_digit_enable_n, out_segments
//
// One request is taken every cycle while in_ready is high; a scan tick's result is offered
// after the tick register, modulo stage, scaling multiplier and output register,
// a byte yields none.
// Reset clears the byte phase, held and shown values, scan position and all stage valids.
// A stalled output holds each stage in place; requests are refused only once every
// stage is full.
module four_digit_decimal_display_scanner import dds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_received_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_digit_enable_n,
  output logic [6:0] out_segments
);

  logic  tick_valid, tick_ready;
  tick_t tick;
  logic  quot_valid, quot_ready;
  quot_t quot;

  dds_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_received_byte (in_received_byte),
    .tick_valid       (tick_valid),
    .tick_ready       (tick_ready),
    .tick             (tick)
  );

  dds_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (tick_valid),
    .up_ready (tick_ready),
    .up       (tick),
    .dn_valid (quot_valid),
    .dn_ready (quot_ready),
    .dn       (quot)
  );

  dds_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (quot_valid),
    .up_ready           (quot_ready),
    .up                 (quot),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_enable_n (out_digit_enable_n),
    .out_segments       (out_segments)
  );

`ifndef SYNTHESIS
  // Requests back up only when every stage holds a result and the output is stalled.
  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while the output is not stalled");

  a_one_digit_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_digit_enable_n) == 3))
    else $error("digit select does not have exactly one active digit");

  // The least significant digit is never blanked.
  a_digit0_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_digit_enable_n == 4'b1110)) |-> (out_segments != 7'h00))
    else $error("least significant digit is dark");
`endif

endmodule

@@ bench/testbench.sv @@
// Testbench of the four-digit decimal display scanner: directed and random requests.
module testbench;
  import dds_pkg::*;

  typedef struct packed {
    logic [3:0] enable_n;
    seg_t       segments;
  } scan_t;

  localparam seg_t GLYPH [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                  7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F};

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_operation = OP_BYTE;
  logic [7:0] in_received_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_digit_enable_n;
  logic [6:0] out_segments;

  // Mirror of the scanner state, advanced on every accepted request.
  logic   byte_phase;
  value_t held_value;
  value_t shown_value;
  pos_t   scan_pos;

  scan_t expected_scans [$];
  int    fail_count = 0;
  int    sent_requests = 0;
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_left = 0;

  four_digit_decimal_display_scanner u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_received_byte   (in_received_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_enable_n (out_digit_enable_n),
    .out_segments       (out_segments)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void store_byte(logic [7:0] data);
    if (byte_phase == 1'b0) begin
      held_value[7:0] = data;
    end else begin
      held_value[15:8] = data;
    end
    byte_phase = ~byte_phase;
  endfunction

  function automatic scan_t predict_scan();
    int unsigned digits [4];
    int unsigned rest;
    int          k;
    logic        blank;
    scan_t       r;
    if (scan_pos == 2'd0) begin
      shown_value = held_value;
    end
    rest = shown_value % 10000;
    for (k = 0; k < 4; k++) begin
      digits[k] = rest % 10;
      rest = rest / 10;
    end
    // A digit is dark while it and every more significant digit are zero.
    case (scan_pos)
      2'd1: blank = (digits[3] | digits[2] | digits[1]) == 0;
      2'd2: blank = (digits[3] | digits[2]) == 0;
      2'd3: blank = digits[3] == 0;
      default: blank = 1'b0;
    endcase
    r.enable_n = ~(4'b0001 << scan_pos);
    r.segments = blank ? 7'h00 : GLYPH[digits[scan_pos]];
    scan_pos = scan_pos + 2'd1;
    return r;
  endfunction

  function automatic void report_mismatch(string what, scan_t exp);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected enable_n=%b segments=%h, got enable_n=%b segments=%h",
               what, exp.enable_n, exp.segments, out_digit_enable_n, out_segments);
    end
  endfunction

  // Predicts on accepted requests and checks every accepted result.
  always @(posedge clk) begin
    scan_t exp;
    if (!rst_n) begin
      byte_phase  = 1'b0;
      held_value  = '0;
      shown_value = '0;
      scan_pos    = '0;
      expected_scans.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_scans.size() == 0) begin
          exp = '0;
          report_mismatch("Unexpected scan result", exp);
        end else begin
          exp = expected_scans.pop_front();
          if (out_digit_enable_n !== exp.enable_n || out_segments !== exp.segments) begin
            report_mismatch("Scan result mismatch", exp);
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        if (in_operation == OP_TICK) begin
          expected_scans.push_back(predict_scan());
        end else begin
          store_byte(in_received_byte);
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off while hold_left counts down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(logic op, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_received_byte <= data;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sent_requests++;
  endtask

  task automatic send_value(value_t v);
    send_request(OP_BYTE, v[7:0]);
    send_request(OP_BYTE, v[15:8]);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_request(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic test_reset_display();
    send_ticks(4);
  endtask

  // Largest value, a wrap to all zeros above 9999, and a trailing zero with a zero low byte.
  task automatic test_extreme_values();
    send_value(16'hFFFF);
    send_ticks(4);
    send_value(16'd10000);
    send_ticks(4);
    send_value(16'h0A00);
    send_ticks(4);
  endtask

  task automatic test_pressure_stall();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    send_value(16'd4321);
    send_ticks(40);
    while (hold_left > 0) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(5))
      0: return value_t'($urandom_range(9));
      1: return value_t'($urandom_range(99));
      2: return value_t'($urandom_range(999));
      3: return value_t'($urandom_range(9999));
      4: return value_t'($urandom_range(65535));
      default: return value_t'(10000 * $urandom_range(6) + $urandom_range(9));
    endcase
  endfunction

  task automatic test_random_traffic(int idle_pct, int stall, int count);
    int goal;
    goal = sent_requests + count;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    while (sent_requests < goal) begin
      if ($urandom_range(99) < 80) begin
        send_value(pick_value());
        send_ticks($urandom_range(8, 1));
      end else begin
        // Noise: loose bytes and ticks that may leave the byte phase odd.
        repeat ($urandom_range(3, 1)) begin
          send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_display();
    test_extreme_values();
    test_pressure_stall();
    test_random_traffic(0, 0, 500);
    test_random_traffic(75, 0, 500);
    test_random_traffic(0, 75, 500);
    test_random_traffic(22, 22, 500);
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
